[design/adpb_pkg.sv]
`default_nettype none
package adpb_pkg;

  // Sequencer states of the block decoder.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_RD,
    S_HDR_LD,
    S_MUL0,
    S_MUL1,
    S_SUM,
    S_OUT
  } state_t;

  // Controls for the per-channel history memory.
  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
  } hist_ctl_t;

  // Controls for the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul;
    logic first;
  } mac_ctl_t;

  typedef logic signed [7:0] coef_t;

  localparam int BLOCK_BYTES = 16;
  localparam logic [3:0] FILTER_MAX = 4'd4;
  localparam int ACC_W = 26;
  localparam int SUM_W = 24;
  localparam logic signed [SUM_W-1:0] SAT_HI = 24'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_LO = -24'sd32768;

  // First tap of the predictor, in 1/64 units.
  function automatic coef_t coef_first(input logic [3:0] filt);
    coef_t c;
    case (filt)
      4'd1: c = 8'sd60;
      4'd2: c = 8'sd115;
      4'd3: c = 8'sd98;
      4'd4: c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Second tap of the predictor, in 1/64 units.
  function automatic coef_t coef_second(input logic [3:0] filt);
    coef_t c;
    case (filt)
      4'd2: c = -8'sd52;
      4'd3: c = -8'sd55;
      4'd4: c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[design/adpb_in_if.sv]
`default_nettype none
interface adpb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_stream;

  modport source(output valid, output data_byte, output start_stream, input ready);
  modport sink(input valid, input data_byte, input start_stream, output ready);
endinterface
`default_nettype wire

[design/adpb_out_if.sv]
`default_nettype none
interface adpb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [2:0]         channel;
  logic [4:0]         sample_index;
  logic               last_of_item;
  logic               bad_filter;

  modport source(output valid, output sample, output channel, output sample_index,
                 output last_of_item, output bad_filter, input ready);
  modport sink(input valid, input sample, input channel, input sample_index,
               input last_of_item, input bad_filter, output ready);
endinterface
`default_nettype wire

[design/adpb_cfg_if.sv]
`default_nettype none
interface adpb_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel_count;

  modport source(output valid, output channel_count, input ready);
  modport sink(input valid, input channel_count, output ready);
endinterface
`default_nettype wire

[design/adpb_hist.sv]
`default_nettype none
// Per-channel history: {last, older} per entry, one write and one registered read.
module adpb_hist #(
  parameter int DEPTH = 8,
  parameter int AW = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire adpb_pkg::hist_ctl_t ctl,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [31:0]       wdata,
  output logic [31:0]            rdata,
  output logic                   rvalid
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
      rvalid <= vld[addr];
    end
  end

  // An entry never written since the last clear reads as zero history.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[addr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[design/adpb_mac.sv]
`default_nettype none
// Shared multiply-accumulate for the prediction, plus the final round and saturate.
module adpb_mac (
  input  wire logic                clk,
  input  wire adpb_pkg::mac_ctl_t  ctl,
  input  wire logic signed [15:0]  a,
  input  wire adpb_pkg::coef_t     c,
  input  wire logic [3:0]          nibble,
  input  wire logic [3:0]          shift,
  output logic signed [15:0]       result
);

  logic signed [23:0]                  prod;
  logic signed [adpb_pkg::ACC_W-1:0]   acc;
  logic signed [adpb_pkg::ACC_W-1:0]   rnd;
  logic signed [19:0]                  pred;
  logic signed [adpb_pkg::SUM_W-1:0]   nib_x;
  logic signed [adpb_pkg::SUM_W-1:0]   sum;

  assign prod = a * c;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      acc <= ctl.first ? adpb_pkg::ACC_W'(prod) : acc + adpb_pkg::ACC_W'(prod);
    end
  end

  always_comb begin
    rnd = acc + 26'sd32;
    // Division by 64 rounding toward zero.
    if (rnd[adpb_pkg::ACC_W-1]) begin
      pred = 20'((rnd + 26'sd63) >>> 6);
    end else begin
      pred = 20'(rnd >>> 6);
    end
    nib_x = adpb_pkg::SUM_W'($signed(nibble)) <<< shift;
    sum = nib_x + adpb_pkg::SUM_W'(pred);
    if (sum > adpb_pkg::SAT_HI) begin
      result = 16'sd32767;
    end else if (sum < adpb_pkg::SAT_LO) begin
      result = -16'sd32768;
    end else begin
      result = sum[15:0];
    end
  end

endmodule
`default_nettype wire

[design/adpcm_block_decoder_top.sv]
// Channel  Role        Word carries
// -------  ----------  ------------------------------------------------------
// stream   input       data_byte, start_stream (header or data byte)
// samples  output      sample, channel, sample_index, last_of_item, bad_filter
// cfg      input       channel_count (always ready)
//
// After a header byte is accepted, the block reads the channel's history from
// memory and loads it, and only then is ready for the next byte.
// For a data byte, each of its two samples takes two passes through the one shared
// multiplier, a round-and-saturate step in which the result is registered, and a
// state in which the word is offered. Stalls on samples hold the word in that state.
// Reset (rst, synchronous) empties the history, clears counters and sets
// channel_count to 1. No clearing pass is needed: history entries carry valid bits.
`default_nettype none
module adpcm_block_decoder_top #(
  parameter int MAX_CHANNELS = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  adpb_in_if.sink   stream,
  adpb_out_if.source samples,
  adpb_cfg_if.sink  cfg
);

  // Width of a channel number.
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  adpb_pkg::state_t    state, state_next;
  adpb_pkg::hist_ctl_t hctl;
  adpb_pkg::mac_ctl_t  mctl;

  logic [3:0]         channel_count;
  logic [3:0]         pos;
  logic [CW-1:0]      chan;
  logic [CW-1:0]      chan_next;
  logic [3:0]         blk_shift;
  logic [3:0]         blk_filter;
  logic [7:0]         byte_q;
  logic               half;
  logic signed [15:0] last_w;
  logic signed [15:0] older_w;
  logic [31:0]        hist_q;
  logic               hist_qv;
  logic signed [15:0] mac_res;
  logic signed [15:0] mac_a;
  adpb_pkg::coef_t    mac_c;
  logic [3:0]         nibble;
  logic               in_acc;
  logic [7:0]         cnt_eff;
  logic [7:0]         next_ch;

  logic               out_vld;
  logic signed [15:0] out_sample;
  logic [2:0]         out_channel;
  logic [4:0]         out_index;
  logic               out_last;
  logic               out_bad;

  assign in_acc = stream.valid && stream.ready;
  assign cfg.ready = 1'b1;

  assign samples.valid        = out_vld;
  assign samples.sample       = out_sample;
  assign samples.channel      = out_channel;
  assign samples.sample_index = out_index;
  assign samples.last_of_item = out_last;
  assign samples.bad_filter   = out_bad;

  // The low nibble is decoded first, then the high nibble.
  assign nibble = half ? byte_q[7:4] : byte_q[3:0];

  // The first multiply pass works on the last sample, the second on the older one.
  assign mac_a = (state == adpb_pkg::S_MUL1) ? older_w : last_w;
  assign mac_c = (state == adpb_pkg::S_MUL1) ? adpb_pkg::coef_second(blk_filter)
                                             : adpb_pkg::coef_first(blk_filter);

  // Next channel at the end of a block; a count of zero acts as one and a
  // count above the number of channels built is limited to it.
  always_comb begin
    if (channel_count == 4'd0) begin
      cnt_eff = 8'd1;
    end else if ({4'd0, channel_count} > 8'(MAX_CHANNELS)) begin
      cnt_eff = 8'(MAX_CHANNELS);
    end else begin
      cnt_eff = {4'd0, channel_count};
    end
    next_ch = 8'(chan) + 8'd1;
    chan_next = (next_ch >= cnt_eff) ? '0 : CW'(next_ch);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adpb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    hctl = '0;
    mctl = '0;
    stream.ready = 1'b0;
    case (state)
      adpb_pkg::S_IDLE: begin
        stream.ready = 1'b1;
        if (in_acc) begin
          hctl.clear = stream.start_stream;
          if (stream.start_stream || pos == 4'd0) begin
            state_next = adpb_pkg::S_HDR_RD;
          end else begin
            state_next = adpb_pkg::S_MUL0;
          end
        end
      end
      adpb_pkg::S_HDR_RD: begin
        hctl.rd = 1'b1;
        state_next = adpb_pkg::S_HDR_LD;
      end
      adpb_pkg::S_HDR_LD: begin
        state_next = adpb_pkg::S_IDLE;
      end
      adpb_pkg::S_MUL0: begin
        mctl.mul = 1'b1;
        mctl.first = 1'b1;
        state_next = adpb_pkg::S_MUL1;
      end
      adpb_pkg::S_MUL1: begin
        mctl.mul = 1'b1;
        state_next = adpb_pkg::S_SUM;
      end
      adpb_pkg::S_SUM: begin
        hctl.wr = 1'b1;
        state_next = adpb_pkg::S_OUT;
      end
      adpb_pkg::S_OUT: begin
        if (samples.ready) begin
          state_next = half ? adpb_pkg::S_IDLE : adpb_pkg::S_MUL0;
        end
      end
      default: begin
        state_next = adpb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 4'd1;
      pos <= '0;
      chan <= '0;
      blk_shift <= '0;
      blk_filter <= '0;
      out_vld <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        channel_count <= cfg.channel_count;
      end
      case (state)
        adpb_pkg::S_IDLE: begin
          if (in_acc) begin
            byte_q <= stream.data_byte;
            half <= 1'b0;
            if (stream.start_stream) begin
              chan <= '0;
            end
            // A start of stream makes this byte a header whatever came before.
            if (stream.start_stream || pos == 4'd0) begin
              blk_shift <= stream.data_byte[3:0];
              blk_filter <= stream.data_byte[7:4];
              pos <= 4'd1;
            end
          end
        end
        adpb_pkg::S_HDR_LD: begin
          last_w <= hist_qv ? hist_q[31:16] : '0;
          older_w <= hist_qv ? hist_q[15:0] : '0;
        end
        adpb_pkg::S_SUM: begin
          out_vld <= 1'b1;
          out_sample <= mac_res;
          out_channel <= 3'(chan);
          out_index <= {pos - 4'd1, half};
          out_last <= half;
          out_bad <= blk_filter > adpb_pkg::FILTER_MAX;
          older_w <= last_w;
          last_w <= mac_res;
        end
        adpb_pkg::S_OUT: begin
          if (samples.ready) begin
            out_vld <= 1'b0;
            if (half) begin
              if (pos == 4'(adpb_pkg::BLOCK_BYTES - 1)) begin
                pos <= '0;
                chan <= chan_next;
              end else begin
                pos <= pos + 4'd1;
              end
            end else begin
              half <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  adpb_hist #(
    .DEPTH(MAX_CHANNELS),
    .AW(CW)
  ) u_hist (
    .clk(clk),
    .rst(rst),
    .ctl(hctl),
    .addr(chan),
    .wdata({mac_res, last_w}),
    .rdata(hist_q),
    .rvalid(hist_qv)
  );

  adpb_mac u_mac (
    .clk(clk),
    .ctl(mctl),
    .a(mac_a),
    .c(mac_c),
    .nibble(nibble),
    .shift(blk_shift),
    .result(mac_res)
  );

endmodule
`default_nettype wire

[design/adpb_checker.sv]
`default_nettype none
module adpb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_sample,
  input wire logic [4:0]  out_index,
  input wire logic        out_last
);

  // The decoder takes no byte while a sample waits.
  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("byte taken while a sample is pending");

  // A sample never appears in the cycle after a byte is taken.
  a_no_instant_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("sample offered too early after a byte");

  // A stalled sample holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("stalled sample changed");

  // The second sample of a byte sits at an odd index within the block, and no index exceeds 29.
  a_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == out_index[0] && out_index <= 5'd29))
    else $error("sample index inconsistent");

endmodule

bind adpcm_block_decoder_top adpb_checker u_adpb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(stream.valid),
  .in_ready(stream.ready),
  .out_valid(samples.valid),
  .out_ready(samples.ready),
  .out_sample(samples.sample),
  .out_index(samples.sample_index),
  .out_last(samples.last_of_item)
);
`default_nettype wire
